@@ rtl/newton_square_root_defines.svh @@
// assertion macros for the newton square root block
// expects clk and rst in scope at the point of use
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// same-cycle implication
`define NSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nsr_pkg.sv @@
// shared constants, types and microcode rom for the newton square root block
// no dependencies
package nsr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int RADICAND_W  = 32;
  localparam int GUESS_W     = RADICAND_W + FRAC_BITS;
  localparam int ROOT_W      = 24;
  localparam int CHANGE_W    = 32;
  localparam int STEPS_W     = 6;
  localparam int TOL_W       = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_CNT_W   = $clog2(GUESS_W + 1);

  localparam logic [TOL_W-1:0]   TOLERANCE_RESET = TOL_W'(66);
  localparam logic [STEPS_W-1:0] MAX_ITER_RESET  = STEPS_W'(32);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER  = CFG_INDEX_W'(1);

  // micro operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 3'd1;
  localparam logic [OP_W-1:0] OP_INIT      = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV_START = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE    = 3'd4;
  localparam logic [OP_W-1:0] OP_CHANGE    = 3'd5;
  localparam logic [OP_W-1:0] OP_EMIT      = 3'd6;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] C_NO_REQ   = 3'd2;
  localparam logic [COND_W-1:0] C_X_ZERO   = 3'd3;
  localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd4;
  localparam logic [COND_W-1:0] C_LOOP     = 3'd5;
  localparam logic [COND_W-1:0] C_OUT_FULL = 3'd6;

  // program addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_ENTRY    = 4'd0;
  localparam logic [PC_W-1:0] PC_INIT     = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV      = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV_WAIT = 4'd3;
  localparam logic [PC_W-1:0] PC_UPDATE   = 4'd4;
  localparam logic [PC_W-1:0] PC_CHANGE   = 4'd5;
  localparam logic [PC_W-1:0] PC_TEST     = 4'd6;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd7;
  localparam logic [PC_W-1:0] PC_RETURN   = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic x_zero;
    logic div_busy;
    logic loop;
    logic out_full;
  } status_t;

  function automatic uword_t uw(logic [OP_W-1:0] op, logic [COND_W-1:0] cond,
                                logic [PC_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // the program: jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_ENTRY:    w = uw(OP_LOAD,      C_NO_REQ,   PC_ENTRY);
      PC_INIT:     w = uw(OP_INIT,      C_X_ZERO,   PC_EMIT);
      PC_DIV:      w = uw(OP_DIV_START, C_NEVER,    PC_ENTRY);
      PC_DIV_WAIT: w = uw(OP_NOP,       C_DIV_BUSY, PC_DIV_WAIT);
      PC_UPDATE:   w = uw(OP_UPDATE,    C_NEVER,    PC_ENTRY);
      PC_CHANGE:   w = uw(OP_CHANGE,    C_NEVER,    PC_ENTRY);
      PC_TEST:     w = uw(OP_NOP,       C_LOOP,     PC_DIV);
      PC_EMIT:     w = uw(OP_EMIT,      C_OUT_FULL, PC_EMIT);
      PC_RETURN:   w = uw(OP_NOP,       C_ALWAYS,   PC_ENTRY);
      default:     w = uw(OP_NOP,       C_ALWAYS,   PC_ENTRY);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/nsr_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on nsr_pkg
module nsr_div import nsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [GUESS_W-1:0] dividend,
  input  logic [GUESS_W-1:0] divisor,
  output logic               busy,
  output logic [GUESS_W-1:0] quotient
);

  logic [GUESS_W-1:0]   rem;
  logic [GUESS_W-1:0]   den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [GUESS_W:0]     partial;
  logic                 fits;
  logic [GUESS_W:0]     trial;

  always_comb begin
    partial = {rem, quotient[GUESS_W-1]};
    fits    = partial >= {1'b0, den};
    trial   = partial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(GUESS_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial[GUESS_W-1:0] : partial[GUESS_W-1:0];
      quotient <= {quotient[GUESS_W-2:0], fits};
    end
  end

endmodule

@@ rtl/nsr_seq.sv @@
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on nsr_pkg
module nsr_seq import nsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  status_t status,
  output ctrl_t   ctrl,
  output logic    idle
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          word;
  logic            taken;

  always_comb begin
    word = ucode_rom(pc);
    unique case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_REQ:   taken = !req_valid;
      C_X_ZERO:   taken = status.x_zero;
      C_DIV_BUSY: taken = status.div_busy;
      C_LOOP:     taken = status.loop;
      C_OUT_FULL: taken = status.out_full;
      default:    taken = 1'b1;
    endcase
    pc_next = taken ? word.target : pc + 1'b1;
    ctrl.op = word.op;
    idle    = pc == PC_ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= PC_ENTRY;
    else     pc <= pc_next;
  end

endmodule

@@ rtl/nsr_dp.sv @@
// datapath: guess registers, newton update, convergence test, result register
// depends on nsr_pkg and nsr_div
module nsr_dp import nsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  input  logic [RADICAND_W-1:0] radicand,
  input  logic [TOL_W-1:0]      tolerance,
  input  logic [STEPS_W-1:0]    max_iterations,
  input  logic                  out_ready,
  output status_t               status,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [CHANGE_W-1:0]   last_change,
  output logic [STEPS_W-1:0]    steps,
  output logic                  converged
);

  logic [RADICAND_W-1:0] x;
  logic [GUESS_W-1:0]    g;
  logic [GUESS_W-1:0]    gprev;
  logic [GUESS_W-1:0]    change;
  logic [STEPS_W-1:0]    step_cnt;
  logic                  done;

  logic [GUESS_W-1:0]    quotient;
  logic                  div_busy;
  logic [GUESS_W:0]      sum;
  logic [GUESS_W-1:0]    half_x;
  logic [GUESS_W-1:0]    diff;
  logic [STEPS_W-1:0]    bound;
  logic                  out_full;
  logic                  emit;

  nsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.op == OP_DIV_START),
    .dividend ({x, FRAC_BITS'(0)}),
    .divisor  (g),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    sum      = {1'b0, g} + {1'b0, quotient};
    half_x   = GUESS_W'(x >> 1);
    diff     = (gprev >= g) ? gprev - g : g - gprev;
    bound    = (max_iterations == '0) ? STEPS_W'(1) : max_iterations;
    out_full = out_valid && !out_ready;
    emit     = (ctrl.op == OP_EMIT) && !out_full;

    status.x_zero   = x == '0;
    status.div_busy = div_busy;
    status.loop     = !done && (step_cnt < bound);
    status.out_full = out_full;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: x <= radicand;
      OP_INIT: begin
        // zero radicand skips the loop; a one-lsb radicand starts at one lsb
        step_cnt <= '0;
        change   <= '0;
        done     <= x == '0;
        if (x == '0)          g <= '0;
        else if (half_x == '0) g <= GUESS_W'(1);
        else                  g <= half_x;
      end
      OP_UPDATE: begin
        gprev    <= g;
        g        <= sum[GUESS_W:1];
        step_cnt <= step_cnt + 1'b1;
      end
      OP_CHANGE: begin
        change <= diff;
        done   <= diff <= GUESS_W'(tolerance);
      end
      default: ;
    endcase
  end

  // result register with saturation to the port widths
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      root        <= (|g[GUESS_W-1:ROOT_W]) ? '1 : g[ROOT_W-1:0];
      last_change <= (|change[GUESS_W-1:CHANGE_W]) ? '1 : change[CHANGE_W-1:0];
      steps       <= step_cnt;
      converged   <= done;
    end
  end

endmodule

@@ rtl/newton_square_root.sv @@
// top level of the newton square root block: ports, configuration registers
// depends on nsr_pkg, nsr_seq, nsr_dp and newton_square_root_defines.svh
//
// Square root of an unsigned Q16.16 radicand by Newton-Raphson iteration.
// The first guess is half the radicand (one lsb if that is zero); each step
// forms g' = (g + (x << 16) / g) / 2 and the loop stops once the change
// |g - g'| is no more than the tolerance register, or after max_iterations
// steps (zero counts as one), in which case converged is low. A zero radicand
// gives root 0, change 0, steps 0, converged high. Root saturates at 24 bits,
// the change at 32 bits. One request is worked on at a time. Each Newton step
// runs the bit-serial divider that forms the 48-by-48-bit quotient, and the
// default bound is 32 steps. A finished result sits in an output register, so
// the next request is taken while the last one waits.
// Configuration: index 0 is tolerance, index 1 is max_iterations; other
// indexes are ignored. cfg_ready is always high.
`include "newton_square_root_defines.svh"

module newton_square_root import nsr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [RADICAND_W-1:0]  radicand,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ROOT_W-1:0]      root,
  output logic [CHANGE_W-1:0]    last_change,
  output logic [STEPS_W-1:0]     steps,
  output logic                   converged,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [TOL_W-1:0]   tolerance;
  logic [STEPS_W-1:0] max_iterations;
  ctrl_t              ctrl;
  status_t            status;
  logic               idle;

  // config writes are always accepted and land on the next clock edge
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOLERANCE_RESET;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TOLERANCE) tolerance <= cfg_data[TOL_W-1:0];
      if (cfg_index == REG_MAX_ITER)  max_iterations <= cfg_data[STEPS_W-1:0];
    end
  end

  // sequencer sits at its entry step while waiting for a request
  nsr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .status    (status),
    .ctrl      (ctrl),
    .idle      (idle)
  );

  assign in_ready = idle;

  // guesses, divider and the result register
  nsr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .radicand       (radicand),
    .tolerance      (tolerance),
    .max_iterations (max_iterations),
    .out_ready      (out_ready),
    .status         (status),
    .out_valid      (out_valid),
    .root           (root),
    .last_change    (last_change),
    .steps          (steps),
    .converged      (converged)
  );

  // a taken request moves the sequencer off its entry step
  `NSR_ASSERT_NEXT(a_leave_entry, in_valid && in_ready, !in_ready,
                   "request accepted but sequencer stayed idle")
  // no steps only for a zero radicand
  `NSR_ASSERT_IMP(a_zero_steps, out_valid && (steps == '0),
                  converged && (root == '0) && (last_change == '0),
                  "zero steps without the zero-radicand result")
  // a converged result must meet the tolerance
  `NSR_ASSERT_IMP(a_conv_tol, out_valid && converged,
                  last_change <= CHANGE_W'(tolerance),
                  "converged result exceeds tolerance")
  // a non-converged result used up the whole bound
  `NSR_ASSERT_IMP(a_bound_hit, out_valid && !converged,
                  (steps == max_iterations) ||
                  ((max_iterations == '0) && (steps == STEPS_W'(1))),
                  "loop stopped early without converging")

endmodule

@@ tb/newton_square_root_tb.sv @@
// self-checking testbench for newton_square_root: fixed-point newton root of a Q16.16 radicand
// depends on nsr_pkg and the rtl of newton_square_root; a scoreboard class predicts each result
module newton_square_root_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsr_pkg::*;

  // watchdog: cycles in a row with no handshake on any channel
  localparam int WATCHDOG_LIMIT = 40000;
  // long output stall used to back the block up
  localparam int HOLD_CYCLES    = 5000;
  // settle time before a register write and after the last result
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 3500;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
    logic [ROOT_W-1:0]     root;
    logic [CHANGE_W-1:0]   change;
    logic [STEPS_W-1:0]    steps;
    logic                  converged;
  } root_expect_t;

  // predicts one result per request and compares against what comes out
  class root_scoreboard;
    root_expect_t       pending[$];
    logic [TOL_W-1:0]   tolerance;
    logic [STEPS_W-1:0] max_iter;
    int unsigned        requests, results, failures;
    int unsigned        zeros, unconverged, saturated;

    function new();
      tolerance = TOLERANCE_RESET;
      max_iter  = MAX_ITER_RESET;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index,
                                 logic [CFG_DATA_W-1:0] data);
      if (index == REG_TOLERANCE)
        tolerance = data[TOL_W-1:0];
      else if (index == REG_MAX_ITER)
        max_iter = data[STEPS_W-1:0];
    endfunction

    // newton iteration on 64-bit integers, same floor rounding as the block
    function void note_request(logic [RADICAND_W-1:0] value);
      root_expect_t want;
      bit [63:0]    x, guess, next, quot, delta;
      int unsigned  count, bound;
      bit           done;
      requests++;
      want.radicand = value;
      x = 64'(value);
      if (x == 0) begin
        zeros++;
        want.root      = '0;
        want.change    = '0;
        want.steps     = '0;
        want.converged = 1'b1;
      end else begin
        bound = (max_iter == 0) ? 1 : int'(max_iter);
        guess = x >> 1;
        if (guess == 0)
          guess = 1;
        count = 0;
        do begin
          quot  = (x << FRAC_BITS) / guess;
          next  = (guess + quot) >> 1;
          delta = (guess > next) ? guess - next : next - guess;
          guess = next;
          count++;
          done  = (delta <= 64'(tolerance));
        end while (!done && count < bound);
        if (guess > 64'hFF_FFFF) begin
          saturated++;
          want.root = '1;
        end else begin
          want.root = guess[ROOT_W-1:0];
        end
        want.change    = (delta > 64'hFFFF_FFFF) ? '1 : delta[CHANGE_W-1:0];
        want.steps     = count[STEPS_W-1:0];
        want.converged = done;
        if (!done)
          unconverged++;
      end
      pending.push_back(want);
    endfunction

    function void check_result(logic [ROOT_W-1:0] root, logic [CHANGE_W-1:0] change,
                               logic [STEPS_W-1:0] steps, logic converged);
      root_expect_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result with no request outstanding: root %h change %h steps %0d conv %b",
                   root, change, steps, converged);
        return;
      end
      want = pending.pop_front();
      results++;
      if (root !== want.root || change !== want.change || steps !== want.steps ||
          converged !== want.converged) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("mismatch for radicand %h", want.radicand);
          $display("  expected root %h change %h steps %0d conv %b",
                   want.root, want.change, want.steps, want.converged);
          $display("  actual   root %h change %h steps %0d conv %b",
                   root, change, steps, converged);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [RADICAND_W-1:0] radicand = '0;

  // result side
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROOT_W-1:0]     root;
  logic [CHANGE_W-1:0]   last_change;
  logic [STEPS_W-1:0]    steps;
  logic                  converged;

  // register write side
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  root_scoreboard board;

  // idle odds in percent, set by the stimulus thread per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // raised once by the stimulus thread, the result thread then stalls on its own
  bit          long_hold_phase = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned settings = 0;

  newton_square_root dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .radicand    (radicand),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .root        (root),
    .last_change (last_change),
    .steps       (steps),
    .converged   (converged),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------

  // offer one radicand; valid is left high so back-to-back requests need no gap
  task automatic send_radicand(input logic [RADICAND_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    radicand <= value;
    do @(posedge clk); while (!in_ready);
    board.note_request(value);
  endtask

  // stop offering and wait until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  // register writes only with the block idle; the optional stray write goes to
  // an index past the two registers and must be ignored
  task automatic configure(input logic [TOL_W-1:0] tol, input logic [STEPS_W-1:0] iters,
                           input bit stray);
    logic [CFG_INDEX_W-1:0] index [3];
    logic [CFG_DATA_W-1:0]  data [3];
    int                     count;
    index[0] = REG_TOLERANCE;
    data[0]  = CFG_DATA_W'(tol);
    index[1] = REG_MAX_ITER;
    // upper data bits are junk, only the low six are the register
    data[1]  = {(CFG_DATA_W-STEPS_W)'($urandom), iters};
    index[2] = CFG_INDEX_W'($urandom_range(255, 2));
    data[2]  = CFG_DATA_W'($urandom);
    count    = stray ? 3 : 2;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < count; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= index[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_register(index[i], data[i]);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // mix of full-range values, every magnitude, values near one and edge values
  function automatic logic [RADICAND_W-1:0] pick_radicand();
    logic [RADICAND_W-1:0] edges [8];
    int unsigned           roll;
    edges = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
              32'h8000_0000, 32'h0001_0000};
    roll = $urandom_range(99);
    if (roll < 50)
      return RADICAND_W'($urandom);
    if (roll < 80)
      return RADICAND_W'($urandom) >> $urandom_range(31);
    if (roll < 90)
      return 32'h0001_0000 + RADICAND_W'($urandom_range(255)) - 32'd128;
    return edges[$urandom_range(7)];
  endfunction

  // one random phase: settle, program the registers, then stream requests
  task automatic run_phase(input int count, input int unsigned send_pct,
                           input int unsigned recv_pct, input logic [TOL_W-1:0] tol,
                           input logic [STEPS_W-1:0] iters, input int pause_at,
                           input int hold_at);
    configure(tol, iters, 1'b0);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      // sender goes quiet until the block has handed back everything
      if (i == pause_at)
        drain();
      // result side stops taking results while requests keep coming
      if (i == hold_at)
        long_hold_phase = 1'b1;
      send_radicand(pick_radicand());
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long stall, checks every result
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_phase && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_result(root, last_change, steps, converged);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any handshake resets the count
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, giving up", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [RADICAND_W-1:0] reset_set [12];
    logic [RADICAND_W-1:0] wide_set [4];
    logic [RADICAND_W-1:0] tight_set [3];
    logic [RADICAND_W-1:0] zero_bound_set [2];
    board = new();
    // reset values: zero, one lsb (first guess forced to one), small, one, four,
    // the extremes and alternating bit patterns
    reset_set = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                  32'h0001_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    // single step: large radicands stay far from their root, and the largest saturates it
    wide_set = '{32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0001, 32'h0000_0000};
    // zero tolerance with the widest bound: the loop ends only on an exact repeat of the guess or at the bound
    tight_set = '{32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0003};
    // bound of zero behaves as one step
    zero_bound_set = '{32'h0009_0000, 32'h1234_5678};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    foreach (reset_set[i])
      send_radicand(reset_set[i]);
    configure(16'hFFFF, 6'd1, 1'b1);
    foreach (wide_set[i])
      send_radicand(wide_set[i]);
    configure(16'd0, 6'd63, 1'b0);
    foreach (tight_set[i])
      send_radicand(tight_set[i]);
    configure(16'd0, 6'd0, 1'b1);
    foreach (zero_bound_set[i])
      send_radicand(zero_bound_set[i]);

    // random part: sender mostly busy with a slow receiver first
    run_phase(150, 7, 64, TOLERANCE_RESET, MAX_ITER_RESET, -1, -1);
    run_phase(140, 7, 64, TOL_W'($urandom_range(255)), 6'd12, 70, -1);
    // then a slow sender with an eager receiver, including the long stall
    run_phase(120, 64, 7, 16'd1, 6'd63, -1, -1);
    run_phase(140, 64, 7, TOL_W'($urandom), STEPS_W'($urandom_range(63, 1)), -1, 20);
    // then neither side idles
    run_phase(150, 0, 0, 16'd0, 6'd8, -1, -1);
    run_phase(150, 0, 0, 16'hFFFF, 6'd0, -1, -1);

    drain();
    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d of %0d requests: %0d zero radicands, %0d stopped by the bound,",
             board.results, board.requests, board.zeros, board.unconverged);
    $display("%0d saturated roots, over %0d register settings and three idle mixes",
             board.saturated, settings);
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures, %0d results never arrived", board.failures,
               board.pending.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
